@@ src/abpse_pkg.sv @@
package abpse_pkg;

    // scan phase codes, the unused code behaves as stopped
    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_UNIT   = 2'd1,
        PH_STOP   = 2'd2
    } t_phase;

    // parameter-set kinds
    localparam logic [1:0] KIND_VPS = 2'd0;
    localparam logic [1:0] KIND_SPS = 2'd1;
    localparam logic [1:0] KIND_PPS = 2'd2;

    // nal unit types, h.264 (5-bit field) and h.265 (6-bit field)
    localparam logic [4:0] AVC_TYPE_SPS  = 5'd7;
    localparam logic [4:0] AVC_TYPE_PPS  = 5'd8;
    localparam logic [5:0] HEVC_TYPE_VPS = 6'd32;
    localparam logic [5:0] HEVC_TYPE_SPS = 6'd33;
    localparam logic [5:0] HEVC_TYPE_PPS = 6'd34;

    // codec select values
    localparam logic CODEC_AVC  = 1'b0;
    localparam logic CODEC_HEVC = 1'b1;

    localparam int HELD_DEPTH  = 4;
    localparam int MAX_RESULTS = 5;

    // scanner state carried from one request to the next
    typedef struct packed {
        t_phase      phase;
        logic [31:0] held;
        logic [2:0]  hcnt;
        logic [1:0]  kind;
        logic        kept;
        logic        started;
    } t_state;

    // one result
    typedef struct packed {
        logic [7:0] unit_byte;
        logic [1:0] set_kind;
        logic       first_of_unit;
        logic       last_of_unit;
    } t_item;

    // control and status between the result buffer and the top level
    typedef struct packed {
        logic valid;
        logic can_load;
    } t_q_stat;

    // pick one held byte, byte 0 is the oldest
    function automatic logic [7:0] get_byte(input logic [31:0] v, input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0: r = v[7:0];
            2'd1: r = v[15:8];
            2'd2: r = v[23:16];
            2'd3: r = v[31:24];
            default: r = v[7:0];
        endcase
        return r;
    endfunction

endpackage

@@ src/abpse_step.sv @@
module abpse_step (
    input  abpse_pkg::t_state                             i_state,
    input  logic                                          i_codec,
    input  logic [7:0]                                    i_data_byte,
    input  logic                                          i_last_byte,
    output abpse_pkg::t_state                             o_state,
    output abpse_pkg::t_item [abpse_pkg::MAX_RESULTS-1:0] o_items,
    output logic [2:0]                                    o_count
);

    abpse_pkg::t_state ns;
    logic [2:0]  cnt;
    logic [2:0]  cnt2;
    logic [2:0]  z;
    logic [2:0]  c;
    logic [2:0]  m;
    logic [2:0]  f;
    logic [2:0]  jm;
    logic        run;
    logic        sc;
    logic        kept1;
    logic [1:0]  kind1;
    logic        kemit;
    logic [1:0]  kind_emit;
    logic [31:0] held_n;

    // one request: start-code window, classification and emission list
    always_comb begin
        ns        = i_state;
        held_n    = i_state.held;
        m         = 3'd0;
        f         = 3'd0;
        c         = 3'd0;
        cnt2      = 3'd0;
        jm        = 3'd0;
        sc        = 1'b0;
        kept1     = i_state.kept;
        kind1     = i_state.kind;
        o_items   = '0;

        cnt = (i_state.hcnt > 3'd4) ? 3'd4 : i_state.hcnt;

        // trailing zeros in the holding buffer
        z   = 3'd0;
        run = 1'b1;
        for (int k = 0; k < abpse_pkg::HELD_DEPTH; k++) begin
            if (run && (3'(k) < cnt) &&
                abpse_pkg::get_byte(i_state.held, 2'(cnt - 3'd1 - 3'(k))) == 8'h00) begin
                z = z + 3'd1;
            end else begin
                run = 1'b0;
            end
        end

        unique case (i_state.phase)
            abpse_pkg::PH_SEARCH: begin
                if (i_data_byte == 8'h00) begin
                    if (i_state.hcnt < 3'd3) begin
                        ns.hcnt = i_state.hcnt + 3'd1;
                    end
                end else if (i_data_byte == 8'h01 && i_state.hcnt >= 3'd2) begin
                    ns.phase   = abpse_pkg::PH_UNIT;
                    ns.hcnt    = 3'd0;
                    ns.started = 1'b0;
                    ns.kept    = 1'b0;
                    ns.kind    = abpse_pkg::KIND_VPS;
                end else begin
                    ns.hcnt = 3'd0;
                end
            end
            abpse_pkg::PH_UNIT: begin
                sc = (i_data_byte == 8'h01) && (z >= 3'd2);
                if (sc) begin
                    // start code closes the unit, up to three zeros before it are dropped
                    c = (z < 3'd3) ? z : 3'd3;
                    if (!i_state.started && cnt == c) begin
                        ns.phase = abpse_pkg::PH_STOP;
                    end else begin
                        m = cnt - c;
                    end
                    ns.hcnt    = 3'd0;
                    ns.started = 1'b0;
                    ns.kept    = 1'b0;
                    ns.kind    = abpse_pkg::KIND_VPS;
                end else begin
                    // header byte sets the kind
                    if (!i_state.started && cnt == 3'd0) begin
                        kept1 = 1'b0;
                        kind1 = abpse_pkg::KIND_VPS;
                        if (i_codec == abpse_pkg::CODEC_AVC) begin
                            if (i_data_byte[4:0] == abpse_pkg::AVC_TYPE_SPS) begin
                                kept1 = 1'b1;
                                kind1 = abpse_pkg::KIND_SPS;
                            end else if (i_data_byte[4:0] == abpse_pkg::AVC_TYPE_PPS) begin
                                kept1 = 1'b1;
                                kind1 = abpse_pkg::KIND_PPS;
                            end
                        end else begin
                            if (i_data_byte[6:1] == abpse_pkg::HEVC_TYPE_VPS) begin
                                kept1 = 1'b1;
                                kind1 = abpse_pkg::KIND_VPS;
                            end else if (i_data_byte[6:1] == abpse_pkg::HEVC_TYPE_SPS) begin
                                kept1 = 1'b1;
                                kind1 = abpse_pkg::KIND_SPS;
                            end else if (i_data_byte[6:1] == abpse_pkg::HEVC_TYPE_PPS) begin
                                kept1 = 1'b1;
                                kind1 = abpse_pkg::KIND_PPS;
                            end
                        end
                        ns.kept = kept1;
                        ns.kind = kind1;
                    end
                    if (i_data_byte != 8'h00) begin
                        // non-zero byte releases everything held
                        m           = cnt;
                        held_n[7:0] = i_data_byte;
                        ns.hcnt     = 3'd1;
                    end else begin
                        // zero byte is held, oldest byte leaves when full
                        if (cnt == 3'd4) begin
                            m      = 3'd1;
                            held_n = {8'h00, i_state.held[31:8]};
                            cnt2   = 3'd3;
                        end else begin
                            cnt2 = cnt;
                        end
                        held_n[{cnt2[1:0], 3'b000} +: 8] = 8'h00;
                        ns.hcnt = cnt2 + 3'd1;
                    end
                    if (m != 3'd0) begin
                        ns.started = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        ns.held = held_n;

        kemit     = sc ? i_state.kept : kept1;
        kind_emit = sc ? i_state.kind : kind1;

        // end of buffer flushes the held bytes as the unit's tail
        if (i_last_byte && ns.phase == abpse_pkg::PH_UNIT) begin
            f = (ns.hcnt > 3'd4) ? 3'd4 : ns.hcnt;
        end

        // results: released bytes first, then the flushed tail
        for (int j = 0; j < abpse_pkg::MAX_RESULTS; j++) begin
            o_items[j].set_kind      = kind_emit;
            o_items[j].first_of_unit = (j == 0) && !i_state.started;
            if (3'(j) < m) begin
                o_items[j].unit_byte    = abpse_pkg::get_byte(i_state.held, 2'(j));
                o_items[j].last_of_unit = sc && (3'(j) == m - 3'd1);
            end else begin
                jm = 3'(j) - m;
                o_items[j].unit_byte    = abpse_pkg::get_byte(held_n, jm[1:0]);
                o_items[j].last_of_unit = (jm == f - 3'd1);
            end
        end

        o_count = kemit ? (m + f) : 3'd0;

        if (i_last_byte) begin
            ns.phase   = abpse_pkg::PH_SEARCH;
            ns.held    = '0;
            ns.hcnt    = 3'd0;
            ns.kind    = abpse_pkg::KIND_VPS;
            ns.kept    = 1'b0;
            ns.started = 1'b0;
        end

        o_state = ns;
    end

endmodule

@@ src/abpse_outq.sv @@
module abpse_outq (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_load,
    input  abpse_pkg::t_item [abpse_pkg::MAX_RESULTS-1:0] i_items,
    input  logic [2:0]                                    i_count,
    input  logic                                          i_pop,
    output abpse_pkg::t_item                              o_head,
    output abpse_pkg::t_q_stat                            o_stat
);

    abpse_pkg::t_item [abpse_pkg::MAX_RESULTS-1:0] r_items;
    logic [2:0] r_left;

    // results leave from slot 0, the rest move down on each taken result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else if (i_load) begin
            r_left <= i_count;
        end else if (i_pop) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_items <= i_items;
        end else if (i_pop) begin
            for (int k = 0; k < abpse_pkg::MAX_RESULTS - 1; k++) begin
                r_items[k] <= r_items[k+1];
            end
        end
    end

    // a new set may load once the last pending result goes out
    assign o_head          = r_items[0];
    assign o_stat.valid    = (r_left != 3'd0);
    assign o_stat.can_load = (r_left == 3'd0) || (r_left == 3'd1 && i_pop);

endmodule

@@ src/annexb_parameter_set_extractor.sv @@
// The first result of a byte shows in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one result and the
// output is not stalled; a byte yielding several results (at most five) holds the
// next byte back until its last result goes out through the single output port.
// Reset (synchronous, active low) returns the scanner to the search for the first
// start code, empties the result buffer and sets codec select to h.264.
module annexb_parameter_set_extractor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_unit_byte,
    output logic [1:0] o_set_kind,
    output logic       o_first_of_unit,
    output logic       o_last_of_unit
);

    abpse_pkg::t_state                             r_state;
    abpse_pkg::t_state                             n_state;
    logic                                          r_codec;
    abpse_pkg::t_item [abpse_pkg::MAX_RESULTS-1:0] step_items;
    logic [2:0]                                    step_count;
    abpse_pkg::t_item                              head;
    abpse_pkg::t_q_stat                            q_stat;
    logic                                          in_acc;
    logic                                          out_pop;

    // codec select register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec <= abpse_pkg::CODEC_AVC;
        end else if (i_cfg_wr_en) begin
            r_codec <= i_cfg_wr_data;
        end
    end

    // handshakes
    assign out_pop    = q_stat.valid && !i_out_stall;
    assign o_in_stall = !q_stat.can_load;
    assign in_acc     = i_in_valid && !o_in_stall;

    abpse_step u_step (
        .i_state     (r_state),
        .i_codec     (r_codec),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_state     (n_state),
        .o_items     (step_items),
        .o_count     (step_count)
    );

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: abpse_pkg::PH_SEARCH, held: 32'h0, hcnt: 3'd0,
                         kind: abpse_pkg::KIND_VPS, kept: 1'b0, started: 1'b0};
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    abpse_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_acc),
        .i_items (step_items),
        .i_count (step_count),
        .i_pop   (out_pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // result port
    assign o_out_valid     = q_stat.valid;
    assign o_unit_byte     = head.unit_byte;
    assign o_set_kind      = head.set_kind;
    assign o_first_of_unit = head.first_of_unit;
    assign o_last_of_unit  = head.last_of_unit;

endmodule

@@ src/abpse_checker.sv @@
module abpse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_unit_byte,
    input logic [1:0] o_set_kind
);

    // a waiting result is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its byte
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_unit_byte))
        else $error("result byte changed while stalled");

    // a new request only goes in when no result is pending or the pending result leaves this cycle
    a_in_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> !o_out_valid || !i_out_stall)
        else $error("request taken while results still pending");

    // the kind code is never the unused value
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_set_kind != 2'd3)
        else $error("unused set kind on result");

    // reset empties the result buffer
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

endmodule

bind annexb_parameter_set_extractor abpse_checker u_abpse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_unit_byte (o_unit_byte),
    .o_set_kind  (o_set_kind)
);
